FILE: sv/mcssr_pkg.sv
// ----------------------------------------------------------------------------
// mcssr_pkg
// shared widths, codes, constants and the per-channel state word of the
// multi-channel servo slew ramp
// ----------------------------------------------------------------------------
`default_nettype none

package mcssr_pkg;

  // channel count default and request field widths
  localparam int CHANNELS_DEF = 4;
  localparam int OP_W         = 3;
  localparam int CH_W         = 4;
  localparam int ANG_IN_W     = 16;
  localparam int RATE_W       = 20;
  localparam int TIME_W       = 32;

  // result field widths
  localparam int KIND_W  = 2;
  localparam int PULSE_W = 12;
  localparam int ANG_W   = 15;

  // opcodes
  localparam logic [OP_W-1:0] OP_SET_TARGET = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_LIMITS = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_RATE   = 3'd2;
  localparam logic [OP_W-1:0] OP_DISABLE    = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK       = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PULSE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STOP   = 2'd3;

  // angles in centidegrees, rates in centidegrees per second
  localparam logic [ANG_W-1:0]   ANGLE_MAX  = 15'd18000;
  localparam logic [TIME_W-1:0]  PERIOD_MS  = 32'd10;
  localparam logic [RATE_W-1:0]  RATE_RESET = 20'd30000;
  localparam logic [PULSE_W-1:0] PULSE_BASE = 12'd500;
  localparam logic [ANG_W-1:0]   PULSE_RND  = 15'd4;

  // step = rate * elapsed / 1000, saturated at ANGLE_MAX
  // rate is never zero, so elapsed beyond the cap always saturates
  localparam int ELAPSED_W = 25;
  localparam logic [ELAPSED_W-1:0] ELAPSED_CAP = 25'd18000000;
  localparam logic [ELAPSED_W-1:0] SAT_PROD    = 25'd18000000;
  localparam int PROD1_W = RATE_W + ELAPSED_W;

  // divide by 1000 through a reciprocal, exact for dividends below 2^25
  localparam int DIV1K_SHIFT = 35;
  localparam int DIV1K_MUL_W = 26;
  localparam logic [DIV1K_MUL_W-1:0] DIV1K_MUL = 26'd34359739;
  localparam int PROD2_W = ELAPSED_W + DIV1K_MUL_W;

  // divide by 9 through a reciprocal, exact for dividends below 2^15
  localparam int DIV9_SHIFT = 18;
  localparam logic [ANG_W-1:0] DIV9_MUL = 15'd29128;
  localparam int PROD3_W = 2 * ANG_W;

  // per-channel word held in the channel memory
  typedef struct packed {
    logic [ANG_W-1:0]  cur;
    logic [ANG_W-1:0]  tgt;
    logic [ANG_W-1:0]  lo;
    logic [ANG_W-1:0]  hi;
    logic [RATE_W-1:0] rate;
  } chan_word_t;

  localparam chan_word_t CHAN_WORD_RESET = '{
    cur:  '0,
    tgt:  '0,
    lo:   '0,
    hi:   ANGLE_MAX,
    rate: RATE_RESET
  };

endpackage

`default_nettype wire

FILE: sv/mcssr_in_if.sv
// ----------------------------------------------------------------------------
// mcssr_in_if
// request channel: valid/ready handshake with the command or tick payload
// ----------------------------------------------------------------------------
`default_nettype none

interface mcssr_in_if import mcssr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            opcode;
  logic [CH_W-1:0]            channel;
  logic signed [ANG_IN_W-1:0] angle_a;
  logic signed [ANG_IN_W-1:0] angle_b;
  logic [RATE_W-1:0]          slew_rate;
  logic [TIME_W-1:0]          now_ms;

  modport source (
    output valid, opcode, channel, angle_a, angle_b, slew_rate, now_ms,
    input  ready
  );

  modport sink (
    input  valid, opcode, channel, angle_a, angle_b, slew_rate, now_ms,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/mcssr_out_if.sv
// ----------------------------------------------------------------------------
// mcssr_out_if
// result channel: valid/ready handshake with one result per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface mcssr_out_if import mcssr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [CH_W-1:0]    chan;
  logic [PULSE_W-1:0] pulse_us;
  logic [ANG_W-1:0]   angle_now;
  logic               is_active;
  logic               last;

  modport source (
    output valid, kind, chan, pulse_us, angle_now, is_active, last,
    input  ready
  );

  modport sink (
    input  valid, kind, chan, pulse_us, angle_now, is_active, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/mcssr_ram.sv
// ----------------------------------------------------------------------------
// mcssr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mcssr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/multi_channel_servo_slew_ramp.sv
// ----------------------------------------------------------------------------
// multi_channel_servo_slew_ramp
// command: decode reads the ram, execute writes back and stages the result,
//   emit registers it once the output is free (out of range: decode to emit),
//   then ready for the next request in idle
// tick: decode, then a read-modify-write walk of the ram over active channels,
//   inactive ones skipped, then a close; seeding or short ticks end in decode;
//   a stalled result holds the walk. reset: active flags, entry valid bits
//   clear at once; unwritten entries read reset limits and rate, no clear pass
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_servo_slew_ramp import mcssr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  mcssr_in_if.sink      in_bus,
  mcssr_out_if.source   out_bus
);

  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(CHANNELS + 1);
  localparam int WORD_W = $bits(chan_word_t);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(CHANNELS);
  localparam logic [CH_W:0]    CH_LIMIT = (CH_W + 1)'(CHANNELS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_EXEC,
    S_SCAN,
    S_MUL1,
    S_MUL2,
    S_UPD,
    S_PULSE,
    S_EMIT
  } state_t;

  // control registers
  state_t              state_r, state_nxt;
  logic [CHANNELS-1:0] active_r, active_nxt;
  logic [CHANNELS-1:0] init_r, init_nxt;
  logic                rd_init_r, rd_init_nxt;
  logic                seeded_r, seeded_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                out_valid_r, out_valid_nxt;

  // request and pipeline payload
  logic [TIME_W-1:0]          base_r, base_nxt;
  logic [OP_W-1:0]            op_r, op_nxt;
  logic [CH_W-1:0]            ch_r, ch_nxt;
  logic signed [ANG_IN_W-1:0] a_r, a_nxt;
  logic signed [ANG_IN_W-1:0] b_r, b_nxt;
  logic [RATE_W-1:0]          rate_r, rate_nxt;
  logic [TIME_W-1:0]          now_r, now_nxt;
  logic [ELAPSED_W-1:0]       el_r, el_nxt;
  chan_word_t                 word_r, word_nxt;
  logic [PROD1_W-1:0]         prod1_r, prod1_nxt;
  logic [PROD2_W-1:0]         prod2_r, prod2_nxt;
  logic                       sat_r, sat_nxt;
  logic [ANG_W-1:0]           cur_new_r, cur_new_nxt;
  logic [PROD3_W-1:0]         prod3_r, prod3_nxt;

  // pending result, moved to the output register once it is free
  logic [KIND_W-1:0] res_kind_r, res_kind_nxt;
  logic [CH_W-1:0]   res_chan_r, res_chan_nxt;
  logic [ANG_W-1:0]  res_angle_r, res_angle_nxt;
  logic              res_act_r, res_act_nxt;
  logic              res_last_r, res_last_nxt;

  // output register
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [CH_W-1:0]    out_chan_r, out_chan_nxt;
  logic [PULSE_W-1:0] out_pulse_r, out_pulse_nxt;
  logic [ANG_W-1:0]   out_angle_r, out_angle_nxt;
  logic               out_act_r, out_act_nxt;
  logic               out_last_r, out_last_nxt;

  // channel ram port
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  chan_word_t        ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // derived values
  chan_word_t           rd_word;
  logic                 ch_ok;
  logic [IDX_W-1:0]     ch_idx, scan_idx;
  logic [TIME_W-1:0]    elapsed;
  logic                 out_free;
  logic                 in_fire;
  logic                 is_tick;

  mcssr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHANNELS)
  ) u_chan_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // an entry never written reads as the reset word
  assign rd_word  = rd_init_r ? chan_word_t'(ram_rdata) : CHAN_WORD_RESET;
  assign ch_ok    = {1'b0, ch_r} < CH_LIMIT;
  assign ch_idx   = ch_r[IDX_W-1:0];
  assign scan_idx = scan_r[IDX_W-1:0];
  assign elapsed  = now_r - base_r;   // wraps modulo 2^32
  assign out_free = !out_valid_r || out_bus.ready;
  assign is_tick  = (op_r == OP_TICK);

  // one request at a time
  assign in_bus.ready = (state_r == S_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;

  assign out_bus.valid     = out_valid_r;
  assign out_bus.kind      = out_kind_r;
  assign out_bus.chan      = out_chan_r;
  assign out_bus.pulse_us  = out_pulse_r;
  assign out_bus.angle_now = out_angle_r;
  assign out_bus.is_active = out_act_r;
  assign out_bus.last      = out_last_r;

  always_comb begin
    logic signed [ANG_IN_W:0] a_x, b_x, lo_x, hi_x;
    logic signed [ANG_W+1:0]  delta, step_x;
    logic [ANG_W-1:0]         tgt_clamp, lim_tgt, step;
    logic                     lim_ok, act_new, above;
    logic [KIND_W-1:0]        kind;
    chan_word_t               wr_word;

    state_nxt     = state_r;
    active_nxt    = active_r;
    init_nxt      = init_r;
    rd_init_nxt   = rd_init_r;
    seeded_nxt    = seeded_r;
    scan_nxt      = scan_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;

    base_nxt    = base_r;
    op_nxt      = op_r;
    ch_nxt      = ch_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    rate_nxt    = rate_r;
    now_nxt     = now_r;
    el_nxt      = el_r;
    word_nxt    = word_r;
    prod1_nxt   = prod1_r;
    prod2_nxt   = prod2_r;
    sat_nxt     = sat_r;
    cur_new_nxt = cur_new_r;
    prod3_nxt   = prod3_r;

    res_kind_nxt  = res_kind_r;
    res_chan_nxt  = res_chan_r;
    res_angle_nxt = res_angle_r;
    res_act_nxt   = res_act_r;
    res_last_nxt  = res_last_r;

    out_kind_nxt  = out_kind_r;
    out_chan_nxt  = out_chan_r;
    out_pulse_nxt = out_pulse_r;
    out_angle_nxt = out_angle_r;
    out_act_nxt   = out_act_r;
    out_last_nxt  = out_last_r;

    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ch_idx;
    ram_raddr = ch_idx;
    ram_wdata = rd_word;

    // command arithmetic on the word just read
    a_x  = {a_r[ANG_IN_W-1], a_r};
    b_x  = {b_r[ANG_IN_W-1], b_r};
    lo_x = {2'b00, rd_word.lo};
    hi_x = {2'b00, rd_word.hi};
    if (a_x < lo_x) begin
      tgt_clamp = rd_word.lo;
    end else if (a_x > hi_x) begin
      tgt_clamp = rd_word.hi;
    end else begin
      tgt_clamp = a_r[ANG_W-1:0];
    end
    lim_ok = !a_r[ANG_IN_W-1] && (b_x <= 17'sd18000) && (a_x < b_x);
    if (rd_word.tgt < a_r[ANG_W-1:0]) begin
      lim_tgt = a_r[ANG_W-1:0];
    end else if (rd_word.tgt > b_r[ANG_W-1:0]) begin
      lim_tgt = b_r[ANG_W-1:0];
    end else begin
      lim_tgt = rd_word.tgt;
    end

    // ramp arithmetic on the captured word
    step   = sat_r ? ANGLE_MAX : prod2_r[DIV1K_SHIFT +: ANG_W];
    step_x = {2'b00, step};
    delta  = $signed({2'b00, word_r.tgt}) - $signed({2'b00, word_r.cur});

    // any active channel after the one in the walk
    above = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (i > int'(scan_idx) && active_r[i]) begin
        above = 1'b1;
      end
    end

    wr_word = rd_word;
    act_new = active_r[ch_idx];
    kind    = KIND_REJECT;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_bus.opcode;
          ch_nxt    = in_bus.channel;
          a_nxt     = in_bus.angle_a;
          b_nxt     = in_bus.angle_b;
          rate_nxt  = in_bus.slew_rate;
          now_nxt   = in_bus.now_ms;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        if (is_tick) begin
          if (!seeded_r) begin
            // first tick only sets the time base
            seeded_nxt = 1'b1;
            base_nxt   = now_r;
            state_nxt  = S_IDLE;
          end else if (elapsed < PERIOD_MS) begin
            state_nxt = S_IDLE;
          end else begin
            base_nxt  = now_r;
            el_nxt    = (elapsed > TIME_W'(ELAPSED_CAP)) ? ELAPSED_CAP
                                                         : elapsed[ELAPSED_W-1:0];
            scan_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end else if (ch_ok) begin
          ram_re      = 1'b1;
          ram_raddr   = ch_idx;
          rd_init_nxt = init_r[ch_idx];
          state_nxt   = S_EXEC;
        end else begin
          // channel out of range
          res_kind_nxt  = KIND_REJECT;
          res_chan_nxt  = ch_r;
          res_angle_nxt = '0;
          res_act_nxt   = 1'b0;
          res_last_nxt  = 1'b1;
          state_nxt     = S_EMIT;
        end
      end

      S_EXEC: begin
        case (op_r)
          OP_SET_TARGET: begin
            wr_word.tgt = tgt_clamp;
            if (!act_new) begin
              act_new     = 1'b1;
              wr_word.cur = tgt_clamp;
            end
            kind = KIND_ACCEPT;
          end
          OP_SET_LIMITS: begin
            if (lim_ok) begin
              wr_word.lo  = a_r[ANG_W-1:0];
              wr_word.hi  = b_r[ANG_W-1:0];
              wr_word.tgt = lim_tgt;
              kind        = KIND_ACCEPT;
            end
          end
          OP_SET_RATE: begin
            if (rate_r != '0) begin
              wr_word.rate = rate_r;
              kind         = KIND_ACCEPT;
            end
          end
          OP_DISABLE: begin
            act_new = 1'b0;
            kind    = KIND_STOP;
          end
          default: begin
          end
        endcase
        ram_we             = 1'b1;
        ram_waddr          = ch_idx;
        ram_wdata          = wr_word;
        init_nxt[ch_idx]   = 1'b1;
        active_nxt[ch_idx] = act_new;
        res_kind_nxt       = kind;
        res_chan_nxt       = ch_r;
        res_angle_nxt      = wr_word.cur;
        res_act_nxt        = act_new;
        res_last_nxt       = 1'b1;
        state_nxt          = S_EMIT;
      end

      S_SCAN: begin
        if (scan_r == SCAN_END) begin
          state_nxt = S_IDLE;
        end else if (active_r[scan_idx]) begin
          ram_re      = 1'b1;
          ram_raddr   = scan_idx;
          rd_init_nxt = init_r[scan_idx];
          state_nxt   = S_MUL1;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end

      S_MUL1: begin
        word_nxt  = rd_word;
        prod1_nxt = PROD1_W'(rd_word.rate) * PROD1_W'(el_r);
        state_nxt = S_MUL2;
      end

      S_MUL2: begin
        sat_nxt   = prod1_r >= PROD1_W'(SAT_PROD);
        prod2_nxt = PROD2_W'(prod1_r[ELAPSED_W-1:0]) * PROD2_W'(DIV1K_MUL);
        state_nxt = S_UPD;
      end

      S_UPD: begin
        if (delta > step_x) begin
          cur_new_nxt = word_r.cur + step;
        end else if (delta < -step_x) begin
          cur_new_nxt = word_r.cur - step;
        end else begin
          cur_new_nxt = word_r.tgt;
        end
        wr_word            = word_r;
        wr_word.cur        = cur_new_nxt;
        ram_we             = 1'b1;
        ram_waddr          = scan_idx;
        ram_wdata          = wr_word;
        init_nxt[scan_idx] = 1'b1;
        res_kind_nxt       = KIND_PULSE;
        res_chan_nxt       = CH_W'(scan_idx);
        res_angle_nxt      = cur_new_nxt;
        res_act_nxt        = 1'b1;
        res_last_nxt       = !above;
        state_nxt          = S_PULSE;
      end

      S_PULSE: begin
        // rounded angle / 9
        prod3_nxt = PROD3_W'(cur_new_r + PULSE_RND) * PROD3_W'(DIV9_MUL);
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_chan_nxt  = res_chan_r;
          out_pulse_nxt = is_tick ? PULSE_BASE + prod3_r[PROD3_W-1:DIV9_SHIFT] : '0;
          out_angle_nxt = res_angle_r;
          out_act_nxt   = res_act_r;
          out_last_nxt  = res_last_r;
          if (is_tick) begin
            scan_nxt  = scan_r + CNT_W'(1);
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    op_r        <= op_nxt;
    ch_r        <= ch_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    rate_r      <= rate_nxt;
    now_r       <= now_nxt;
    el_r        <= el_nxt;
    word_r      <= word_nxt;
    prod1_r     <= prod1_nxt;
    prod2_r     <= prod2_nxt;
    sat_r       <= sat_nxt;
    cur_new_r   <= cur_new_nxt;
    prod3_r     <= prod3_nxt;
    rd_init_r   <= rd_init_nxt;
    res_kind_r  <= res_kind_nxt;
    res_chan_r  <= res_chan_nxt;
    res_angle_r <= res_angle_nxt;
    res_act_r   <= res_act_nxt;
    res_last_r  <= res_last_nxt;
    out_kind_r  <= out_kind_nxt;
    out_chan_r  <= out_chan_nxt;
    out_pulse_r <= out_pulse_nxt;
    out_angle_r <= out_angle_nxt;
    out_act_r   <= out_act_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      init_r      <= '0;
      seeded_r    <= 1'b0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      init_r      <= init_nxt;
      seeded_r    <= seeded_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // pulse results and only they carry a nonzero width
  a_pulse_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == KIND_PULSE) == (out_pulse_r != '0)))
    else $error("pulse width does not match result kind");

  // a pulse stays within the servo range and its angle within limits
  a_pulse_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_PULSE) |->
      (out_pulse_r >= PULSE_BASE && out_pulse_r <= 12'd2500 &&
       out_angle_r <= ANGLE_MAX && out_act_r))
    else $error("pulse result out of range");

  // read and write-back of the channel ram never overlap
  a_ram_interlock : assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("channel ram read and write in the same cycle");

  // once the time base is seeded it stays seeded
  a_seed_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("time base lost its seed");

endmodule

`default_nettype wire
